// ===== hdl/sedb_pkg.sv =====
// ----------------------------------------------------------------------------
// sedb_pkg: shared definitions for the Sobel edge direction binner
// Dimensions, field widths, codes, pipeline payload types and helpers.
// ----------------------------------------------------------------------------
package sedb_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int PIX_W   = 8;
  localparam int DIM_W   = 11;
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int DIR_W   = 3;
  localparam int CIDX_W  = 2;
  localparam int THR_SQ_W = 2 * DIM_W;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 24;
  localparam int LUMA_SUM_W  = 16;

  localparam logic [DIM_W-1:0] FRAME_WIDTH_RESET    = 11'd640;
  localparam logic [DIM_W-1:0] FRAME_HEIGHT_RESET   = 11'd480;
  localparam logic [DIM_W-1:0] EDGE_THRESHOLD_RESET = 11'd64;

  // Luma weights in Q8 with rounding.
  localparam logic [LUMA_SUM_W-1:0] LUMA_R     = 16'd54;
  localparam logic [LUMA_SUM_W-1:0] LUMA_G     = 16'd184;
  localparam logic [LUMA_SUM_W-1:0] LUMA_B     = 16'd18;
  localparam logic [LUMA_SUM_W-1:0] LUMA_ROUND = 16'd128;

  // Tangents of the bin boundaries in Q16.
  localparam logic [15:0] TAN36_Q16 = 16'd47615;
  localparam logic [15:0] TAN18_Q16 = 16'd21294;

  localparam logic [DIR_W-1:0] DIR_WEAK = 3'd0;
  localparam logic [DIR_W-1:0] DIR_BIN1 = 3'd1;
  localparam logic [DIR_W-1:0] DIR_BIN2 = 3'd2;
  localparam logic [DIR_W-1:0] DIR_BIN3 = 3'd3;
  localparam logic [DIR_W-1:0] DIR_BIN4 = 3'd4;
  localparam logic [DIR_W-1:0] DIR_BIN5 = 3'd5;
  localparam logic [DIR_W-1:0] DIR_180  = 3'd6;

  localparam logic MODE_PIXEL = 1'b0;
  localparam logic MODE_FLUSH = 1'b1;

  localparam logic [CIDX_W-1:0] CFG_FRAME_WIDTH    = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_FRAME_HEIGHT   = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_EDGE_THRESHOLD = 2'd2;

  // 3x3 window, entry row*3+col, row 0 on top, col 0 on the left.
  typedef logic [8:0][PIX_W-1:0] win_t;

  // One line store entry: the older row and the newer row of a column.
  typedef struct packed {
    logic [PIX_W-1:0] upper;
    logic [PIX_W-1:0] lower;
  } line_t;

  // Work handed from the front end to the classifier stage.
  typedef struct packed {
    logic             valid;
    logic             emit_a;
    logic             emit_b;
    logic             frame_last;
    logic [COL_W-1:0] col_a;
    logic [COL_W-1:0] col_b;
    logic [ROW_W-1:0] row;
    win_t             win;
  } job_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > maxv) begin
      r = maxv;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ===== hdl/sedb_ram.sv =====
// ----------------------------------------------------------------------------
// sedb_ram: generic single-port-write, single-port-read RAM
// Registered read; a read at the address being written returns the old data.
// ----------------------------------------------------------------------------
module sedb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/sedb_classify.sv =====
// ----------------------------------------------------------------------------
// sedb_classify: Sobel gradient and direction bin of one 3x3 window
// Magnitude test against the squared threshold, then Q16 tangent compares.
// ----------------------------------------------------------------------------
module sedb_classify import sedb_pkg::*; (
  input  win_t                win,
  input  logic [THR_SQ_W-1:0] thr_sq,
  output logic [DIR_W-1:0]    dir
);

  logic [9:0]  xr, xl, yt, yb;
  logic [9:0]  ax, ay;
  logic        gx_neg, gx_pos, gy_pos, gy_zero;
  logic [19:0] sq_x, sq_y;
  logic [20:0] mag;
  logic        below_thr;
  logic [25:0] ax_sh, ay_sh, t36_ax, t18_ay;

  assign xr = 10'(win[2]) + {1'b0, win[5], 1'b0} + 10'(win[8]);
  assign xl = 10'(win[0]) + {1'b0, win[3], 1'b0} + 10'(win[6]);
  assign yt = 10'(win[0]) + {1'b0, win[1], 1'b0} + 10'(win[2]);
  assign yb = 10'(win[6]) + {1'b0, win[7], 1'b0} + 10'(win[8]);

  assign gx_neg  = xr < xl;
  assign gx_pos  = xr > xl;
  assign gy_pos  = yt > yb;
  assign gy_zero = yt == yb;
  assign ax = gx_neg ? xl - xr : xr - xl;
  assign ay = (yt < yb) ? yb - yt : yt - yb;

  assign sq_x = ax * ax;
  assign sq_y = ay * ay;
  assign mag  = {1'b0, sq_x} + {1'b0, sq_y};
  assign below_thr = {1'b0, mag} < thr_sq;

  assign ax_sh  = {ax, 16'd0};
  assign ay_sh  = {ay, 16'd0};
  assign t36_ax = TAN36_Q16 * ax;
  assign t18_ay = TAN18_Q16 * ay;

  always_comb begin
    if (below_thr) begin
      dir = DIR_WEAK;
    end else if (gy_zero) begin
      dir = gx_neg ? DIR_180 : DIR_BIN3;
    end else if (gy_pos) begin
      if (gx_pos && (ay_sh < t36_ax)) begin
        dir = DIR_BIN3;
      end else if (gx_neg && (ax_sh >= t18_ay)) begin
        dir = DIR_BIN5;
      end else begin
        dir = DIR_BIN4;
      end
    end else begin
      if (gx_pos && (ay_sh <= t36_ax)) begin
        dir = DIR_BIN3;
      end else if (gx_neg && (ax_sh > t18_ay)) begin
        dir = DIR_BIN1;
      end else begin
        dir = DIR_BIN2;
      end
    end
  end

endmodule

// ===== hdl/sedb_front.sv =====
// ----------------------------------------------------------------------------
// sedb_front: input side of the binner
// Luma, line store, 3x3 window, raster counters, drain of the last row and
// configuration registers. Builds at most one classifier job per accepted request.
// ----------------------------------------------------------------------------
module sedb_front import sedb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_TDATA_W-1:0] s_tdata,
  input  logic                  s_tuser,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CIDX_W-1:0]     cfg_index,
  input  logic [DIM_W-1:0]      cfg_data,
  input  logic                  back_ready,
  output job_t                  job,
  output logic [THR_SQ_W-1:0]   thr_sq
);

  logic [DIM_W-1:0] frame_width, frame_height, edge_threshold;
  logic [DIM_W-1:0] w_eff, h_eff;

  logic [COL_W-1:0] in_col, in_col_next;
  logic [ROW_W-1:0] in_row, in_row_next;
  logic [COL_W-1:0] drain_col, drain_col_next;
  logic             drain_pending, drain_pending_next;
  win_t             win_regs, win_next;
  line_t            dwin_l, dwin_l_next, dwin_c, dwin_c_next;
  line_t            cap0, cap0_next;
  job_t             job_next;

  logic                  accept;
  logic [PIX_W-1:0]      red, green, blue, luma;
  logic [LUMA_SUM_W-1:0] luma_sum;
  logic [PIX_W-1:0]      top, mid;
  win_t                  wbase, pwin, dwin;
  logic                  row_end, frame_end;
  logic [DIM_W-1:0]      d_ext;
  logic                  okl, okc, okr, dlast;

  logic             ram_we;
  logic [COL_W-1:0] ram_waddr, rd_addr;
  line_t            ram_wdata, rd_line, fwd_data;
  logic [$bits(line_t)-1:0] ram_q;
  logic             fwd_hit, fwd_hit_q;

  assign cfg_ready = 1'b1;
  assign s_tready  = !job.valid || back_ready;
  assign accept    = s_tvalid && s_tready;

  assign w_eff = clamp_dim(frame_width, DIM_W'(MAX_WIDTH));
  assign h_eff = clamp_dim(frame_height, DIM_W'(MAX_HEIGHT));

  assign red   = s_tdata[7:0];
  assign green = s_tdata[15:8];
  assign blue  = s_tdata[23:16];
  assign luma_sum = LUMA_R * LUMA_SUM_W'(red) + LUMA_G * LUMA_SUM_W'(green)
                  + LUMA_B * LUMA_SUM_W'(blue) + LUMA_ROUND;
  assign luma = luma_sum[LUMA_SUM_W-1 -: PIX_W];

  // The read port always holds the entry for the next request: the current
  // column while a row streams in, column drain_col+1 while a drain waits.
  assign rd_line = fwd_hit_q ? fwd_data : line_t'(ram_q);

  assign top = (in_row >= ROW_W'(2)) ? rd_line.upper : '0;
  assign mid = (in_row != '0) ? rd_line.lower : '0;

  assign row_end   = ({1'b0, in_col} + DIM_W'(1)) >= w_eff;
  assign frame_end = row_end && (({1'b0, in_row} + DIM_W'(1)) >= h_eff);

  always_comb begin
    wbase = (in_col == '0) ? '0 : win_regs;
    pwin  = wbase;
    for (int i = 0; i < 3; i++) begin
      pwin[i*3]   = wbase[i*3+1];
      pwin[i*3+1] = wbase[i*3+2];
    end
    pwin[2] = top;
    pwin[5] = mid;
    pwin[8] = luma;
  end

  assign d_ext = {1'b0, drain_col};
  assign okl   = (drain_col != '0) && ((d_ext - DIM_W'(1)) < w_eff);
  assign okc   = d_ext < w_eff;
  assign okr   = (d_ext + DIM_W'(1)) < w_eff;
  assign dlast = (d_ext + DIM_W'(1)) >= w_eff;

  // The row below the last row counts as zero.
  always_comb begin
    dwin    = '0;
    dwin[0] = okl ? dwin_l.upper : '0;
    dwin[1] = okc ? dwin_c.upper : '0;
    dwin[2] = okr ? rd_line.upper : '0;
    dwin[3] = okl ? dwin_l.lower : '0;
    dwin[4] = okc ? dwin_c.lower : '0;
    dwin[5] = okr ? rd_line.lower : '0;
  end

  always_comb begin
    in_col_next        = in_col;
    in_row_next        = in_row;
    drain_col_next     = drain_col;
    drain_pending_next = drain_pending;
    win_next           = win_regs;
    dwin_l_next        = dwin_l;
    dwin_c_next        = dwin_c;
    cap0_next          = cap0;
    job_next           = job;
    ram_we             = 1'b0;
    ram_waddr          = in_col;
    ram_wdata.upper    = mid;
    ram_wdata.lower    = luma;
    if (job.valid && back_ready) begin
      job_next.valid = 1'b0;
    end
    if (accept) begin
      if (s_tuser == MODE_FLUSH) begin
        if (drain_pending) begin
          job_next.valid      = 1'b1;
          job_next.emit_a     = 1'b1;
          job_next.emit_b     = 1'b0;
          job_next.frame_last = dlast;
          job_next.col_a      = drain_col;
          job_next.col_b      = drain_col;
          job_next.row        = ROW_W'(h_eff - DIM_W'(1));
          job_next.win        = dwin;
          dwin_l_next         = dwin_c;
          dwin_c_next         = rd_line;
          if (dlast) begin
            drain_pending_next = 1'b0;
            drain_col_next     = '0;
          end else begin
            drain_col_next = drain_col + COL_W'(1);
          end
        end
      end else begin
        ram_we             = 1'b1;
        win_next           = pwin;
        drain_pending_next = 1'b0;
        drain_col_next     = '0;
        if (in_col == '0) begin
          cap0_next = ram_wdata;
        end
        job_next.emit_a     = (in_row != '0) && (in_col != '0);
        job_next.emit_b     = (in_row != '0) && row_end;
        job_next.valid      = job_next.emit_a || job_next.emit_b;
        job_next.frame_last = 1'b0;
        job_next.col_a      = in_col - COL_W'(1);
        job_next.col_b      = in_col;
        job_next.row        = in_row - ROW_W'(1);
        job_next.win        = pwin;
        if (row_end) begin
          in_col_next = '0;
          if (frame_end) begin
            in_row_next        = '0;
            drain_pending_next = 1'b1;
            dwin_l_next        = '0;
            dwin_c_next        = cap0_next;
          end else begin
            in_row_next = in_row + ROW_W'(1);
          end
        end else begin
          in_col_next = in_col + COL_W'(1);
        end
      end
    end
  end

  assign rd_addr = drain_pending_next ? drain_col_next + COL_W'(1) : in_col_next;
  assign fwd_hit = ram_we && (ram_waddr == rd_addr);

  sedb_ram #(
    .WIDTH ($bits(line_t)),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_col         <= '0;
      in_row         <= '0;
      drain_col      <= '0;
      drain_pending  <= 1'b0;
      job.valid      <= 1'b0;
      frame_width    <= FRAME_WIDTH_RESET;
      frame_height   <= FRAME_HEIGHT_RESET;
      edge_threshold <= EDGE_THRESHOLD_RESET;
    end else begin
      in_col        <= in_col_next;
      in_row        <= in_row_next;
      drain_col     <= drain_col_next;
      drain_pending <= drain_pending_next;
      job           <= job_next;
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_FRAME_WIDTH:    frame_width    <= cfg_data;
          CFG_FRAME_HEIGHT:   frame_height   <= cfg_data;
          CFG_EDGE_THRESHOLD: edge_threshold <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    win_regs  <= win_next;
    dwin_l    <= dwin_l_next;
    dwin_c    <= dwin_c_next;
    cap0      <= cap0_next;
    fwd_hit_q <= fwd_hit;
    fwd_data  <= ram_wdata;
    thr_sq    <= edge_threshold * edge_threshold;
  end

endmodule

// ===== hdl/sedb_back.sv =====
// ----------------------------------------------------------------------------
// sedb_back: classifier stage and result register
// Classifies the job window and, at a row end, the window shifted one column
// further with a zero column, then hands the results out one at a time.
// ----------------------------------------------------------------------------
module sedb_back import sedb_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  job_t                   job,
  input  logic [THR_SQ_W-1:0]    thr_sq,
  output logic                   back_ready,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,
  output logic                   m_tlast,
  output logic                   m_tuser
);

  typedef struct packed {
    logic [DIR_W-1:0] dir;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             run_last;
    logic             frame_last;
  } res_t;

  win_t             win_b;
  logic [DIR_W-1:0] dir_a, dir_b;
  res_t             res_a, res_b, out_res;
  logic             pend_a, pend_b;
  logic             load, pop;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      win_b[i*3]   = job.win[i*3+1];
      win_b[i*3+1] = job.win[i*3+2];
      win_b[i*3+2] = '0;
    end
  end

  sedb_classify u_cls_a (
    .win    (job.win),
    .thr_sq (thr_sq),
    .dir    (dir_a)
  );

  sedb_classify u_cls_b (
    .win    (win_b),
    .thr_sq (thr_sq),
    .dir    (dir_b)
  );

  assign m_tvalid = pend_a || pend_b;
  assign pop      = m_tvalid && m_tready;
  // Free when empty, or when the single result left goes out this cycle.
  assign back_ready = (!pend_a && !pend_b) || ((pend_a ^ pend_b) && m_tready);
  assign load       = job.valid && back_ready;

  assign out_res = pend_a ? res_a : res_b;
  assign m_tdata = OUT_TDATA_W'({out_res.row, out_res.col, out_res.dir});
  assign m_tlast = out_res.run_last;
  assign m_tuser = out_res.frame_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_a <= 1'b0;
      pend_b <= 1'b0;
    end else if (load) begin
      pend_a <= job.emit_a;
      pend_b <= job.emit_b;
    end else if (pop) begin
      if (pend_a) begin
        pend_a <= 1'b0;
      end else begin
        pend_b <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_a.dir        <= dir_a;
      res_a.col        <= job.col_a;
      res_a.row        <= job.row;
      res_a.run_last   <= !job.emit_b;
      res_a.frame_last <= job.frame_last;
      res_b.dir        <= dir_b;
      res_b.col        <= job.col_b;
      res_b.row        <= job.row;
      res_b.run_last   <= 1'b1;
      res_b.frame_last <= 1'b0;
    end
  end

endmodule

// ===== hdl/sobel_edge_direction_binner.sv =====
// ----------------------------------------------------------------------------
// sobel_edge_direction_binner: Sobel gradient direction bins of an RGB stream
// Path: a result passes through the job register and the result register.
// Throughput: one request per cycle unless the output stalls. A row end that
// gives two results holds the output register for both, so the input stalls.
// Reset clears counters, drain state and handshakes and restores the
// registers; line store contents stay undefined, with no clearing pass.
// ----------------------------------------------------------------------------
module sobel_edge_direction_binner import sedb_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // red, green, blue
  input  logic                   s_tuser,   // mode
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // direction, out_col, out_row
  output logic                   m_tlast,
  output logic                   m_tuser,   // frame_last
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CIDX_W-1:0]      cfg_index,
  input  logic [DIM_W-1:0]       cfg_data
);

  job_t                job;
  logic                back_ready;
  logic [THR_SQ_W-1:0] thr_sq;

  sedb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .back_ready (back_ready),
    .job        (job),
    .thr_sq     (thr_sq)
  );

  sedb_back u_back (
    .clk        (clk),
    .rst        (rst),
    .job        (job),
    .thr_sq     (thr_sq),
    .back_ready (back_ready),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .m_tuser    (m_tuser)
  );

endmodule
